>>> src/psr_pkg.sv
// shared constants and types for the panel serial register port
package psr_pkg;

    localparam logic [1:0] FUNC_BIT   = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_INDEX = 3'd1;
    localparam logic [2:0] PH_GAP   = 3'd2;
    localparam logic [2:0] PH_WVAL  = 3'd3;
    localparam logic [2:0] PH_RCMD  = 3'd4;
    localparam logic [2:0] PH_RIN   = 3'd5;

    localparam int unsigned FRAME_BITS = 24;
    localparam int unsigned CNT_W      = 5;

    localparam logic [7:0] HDR_INDEX = 8'h70;
    localparam logic [7:0] HDR_WVAL  = 8'h72;
    localparam logic [7:0] HDR_RCMD  = 8'h73;

    localparam logic [CNT_W-1:0] CNT_FRAME = CNT_W'(FRAME_BITS);
    localparam logic [CNT_W-1:0] CNT_BYTE  = CNT_W'(8);

    typedef struct packed {
        logic        cs_n;
        logic        sdo;
        logic        sclk_pulse;
        logic        busy_res;
        logic [15:0] read_data;
        logic        read_valid;
        logic        cmd_rejected;
    } res_t;

endpackage

>>> src/psr_core.sv
// transfer sequencer: frame shift registers, bit counter and phase
module psr_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [1:0]            func,
    input  logic [15:0]           reg_addr,
    input  logic [15:0]           reg_value,
    input  logic                  sdi_bit,
    output psr_pkg::res_t         res
);

    logic [23:0]                tx_shift_reg, tx_shift_next;
    logic [23:0]                rx_shift_reg, rx_shift_next;
    logic [psr_pkg::CNT_W-1:0]  bit_left_reg, bit_left_next;
    logic [2:0]                 phase_reg, phase_next;
    logic                       is_read_reg, is_read_next;
    logic [15:0]                held_value_reg, held_value_next;

    logic                       start;
    logic                       active;
    logic [2:0]                 ph_eff;
    logic [23:0]                tx_eff;
    logic [psr_pkg::CNT_W-1:0]  cnt_eff;
    logic [psr_pkg::CNT_W-1:0]  cnt_dec;
    logic [23:0]                rx_new;

    always_comb
    begin
        start  = (func == psr_pkg::FUNC_WRITE) || (func == psr_pkg::FUNC_READ);
        active = (phase_reg >= psr_pkg::PH_INDEX) && (phase_reg <= psr_pkg::PH_RIN);

        tx_shift_next   = tx_shift_reg;
        rx_shift_next   = rx_shift_reg;
        is_read_next    = is_read_reg;
        held_value_next = held_value_reg;

        res              = '0;
        res.cs_n         = 1'b1;
        res.cmd_rejected = active && start;

        // a start from idle loads the index frame and sends its first bit now
        ph_eff  = phase_reg;
        tx_eff  = tx_shift_reg;
        cnt_eff = bit_left_reg;
        if (!active)
        begin
            ph_eff = psr_pkg::PH_IDLE;
            if (start)
            begin
                ph_eff          = psr_pkg::PH_INDEX;
                tx_eff          = {psr_pkg::HDR_INDEX, reg_addr};
                cnt_eff         = psr_pkg::CNT_FRAME;
                is_read_next    = (func == psr_pkg::FUNC_READ);
                held_value_next = reg_value;
            end
        end

        cnt_dec = (cnt_eff != '0) ? cnt_eff - 1'b1 : cnt_eff;
        rx_new  = {rx_shift_reg[22:0], sdi_bit};

        phase_next    = ph_eff;
        bit_left_next = cnt_eff;
        tx_shift_next = tx_eff;

        case (ph_eff)
            psr_pkg::PH_INDEX, psr_pkg::PH_WVAL, psr_pkg::PH_RCMD:
            begin
                res.cs_n       = 1'b0;
                res.sdo        = tx_eff[23];
                res.sclk_pulse = 1'b1;
                tx_shift_next  = {tx_eff[22:0], 1'b0};
                bit_left_next  = cnt_dec;
                if (cnt_dec == '0)
                begin
                    case (ph_eff)
                        psr_pkg::PH_INDEX: phase_next = psr_pkg::PH_GAP;
                        psr_pkg::PH_RCMD:
                        begin
                            rx_shift_next = '0;
                            bit_left_next = psr_pkg::CNT_FRAME;
                            phase_next    = psr_pkg::PH_RIN;
                        end
                        default: phase_next = psr_pkg::PH_IDLE;
                    endcase
                end
            end
            psr_pkg::PH_GAP:
            begin
                // chip select high for one period, then load the second frame
                if (is_read_reg)
                begin
                    tx_shift_next = {psr_pkg::HDR_RCMD, 16'h0000};
                    bit_left_next = psr_pkg::CNT_BYTE;
                    phase_next    = psr_pkg::PH_RCMD;
                end
                else
                begin
                    tx_shift_next = {psr_pkg::HDR_WVAL, held_value_reg};
                    bit_left_next = psr_pkg::CNT_FRAME;
                    phase_next    = psr_pkg::PH_WVAL;
                end
            end
            psr_pkg::PH_RIN:
            begin
                res.cs_n       = 1'b0;
                res.sclk_pulse = 1'b1;
                rx_shift_next  = rx_new;
                bit_left_next  = cnt_dec;
                if (cnt_dec == '0)
                begin
                    // middle byte of the received frame is dropped
                    res.read_data  = {rx_new[23:16], rx_new[7:0]};
                    res.read_valid = 1'b1;
                    phase_next     = psr_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = psr_pkg::PH_IDLE;
            end
        endcase

        res.busy_res = (phase_next != psr_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg   <= '0;
            rx_shift_reg   <= '0;
            bit_left_reg   <= '0;
            phase_reg      <= psr_pkg::PH_IDLE;
            is_read_reg    <= 1'b0;
            held_value_reg <= '0;
        end
        else if (step)
        begin
            tx_shift_reg   <= tx_shift_next;
            rx_shift_reg   <= rx_shift_next;
            bit_left_reg   <= bit_left_next;
            phase_reg      <= phase_next;
            is_read_reg    <= is_read_next;
            held_value_reg <= held_value_next;
        end
    end

endmodule

>>> src/panel_serial_register_port.sv
// top level of the panel serial register port
// usage:
//   each input word is one serial bit period on the panel's three-wire port.
//   func selects a plain period, a register write start or a register read
//   start; reg_addr and reg_value are taken in the start period.
//   each input word yields exactly one output word carrying cs_n, sdo,
//   sclk_pulse, busy_res, and on the last read period read_valid with
//   read_data; cmd_rejected flags a start that arrived while busy.
//   an input register, then one pass of the sequencer logic into the output
//   register. throughput is one word per cycle while the receiver does not
//   stall, set by the update of the phase, counter and shift registers.
//   a write takes 49 periods, a read 57 periods (index frame, gap period,
//   command byte, 24 input bits).
//   reset clears the sequencer to idle and empties both register stages.
//   when the receiver stalls, the output word holds, and the input stage
//   fills and then stalls the sender; no word is dropped or repeated.
module panel_serial_register_port
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] reg_addr,
    input  logic [15:0] reg_value,
    input  logic        sdi_bit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        cs_n,
    output logic        sdo,
    output logic        sclk_pulse,
    output logic        busy_res,
    output logic [15:0] read_data,
    output logic        read_valid,
    output logic        cmd_rejected
);

    logic          in_valid_reg;
    logic [1:0]    func_reg;
    logic [15:0]   reg_addr_reg;
    logic [15:0]   reg_value_reg;
    logic          sdi_bit_reg;
    logic          out_valid_reg;
    psr_pkg::res_t res_reg;
    psr_pkg::res_t res_next;
    logic          out_free;
    logic          step;
    logic          in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    psr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .func      (func_reg),
        .reg_addr  (reg_addr_reg),
        .reg_value (reg_value_reg),
        .sdi_bit   (sdi_bit_reg),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg      <= func;
            reg_addr_reg  <= reg_addr;
            reg_value_reg <= reg_value;
            sdi_bit_reg   <= sdi_bit;
        end
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cs_n         = res_reg.cs_n;
    assign sdo          = res_reg.sdo;
    assign sclk_pulse   = res_reg.sclk_pulse;
    assign busy_res     = res_reg.busy_res;
    assign read_data    = res_reg.read_data;
    assign read_valid   = res_reg.read_valid;
    assign cmd_rejected = res_reg.cmd_rejected;

endmodule
